>>> rtl/sfa_pkg.sv
// ----------------------------------------------------------------------------
// sfa_pkg: shared constants for the secp256k1 field ALU
// Field prime, operation codes and widths.
// ----------------------------------------------------------------------------
`default_nettype none
package sfa_pkg;
    localparam int unsigned FieldW = 256;
    localparam int unsigned LimbW  = 64;
    localparam logic [FieldW-1:0] Prime =
        256'hFFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFF_FFFFFFFE_FFFFFC2F;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_NEG = 3'd2,
        OP_MUL = 3'd3,
        OP_INV = 3'd4
    } t_op;
endpackage
`default_nettype wire

>>> rtl/sfa_core.sv
// ----------------------------------------------------------------------------
// sfa_core: bit-serial field engine
// Add/sub/neg one bit per cycle; multiply by MSB-first double-and-add with a
// modular reduction each step; inverse by binary extended Euclid, one
// shift or subtract step per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module sfa_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [2:0]                    i_op,
    input  wire logic [sfa_pkg::FieldW-1:0]    i_a,
    input  wire logic [sfa_pkg::FieldW-1:0]    i_b,
    output logic                               o_done,
    output logic [sfa_pkg::FieldW-1:0]         o_res,
    output logic                               o_zero_inv
);
    localparam int unsigned W  = sfa_pkg::FieldW;
    localparam int unsigned CW = $clog2(W + 1);
    localparam logic [W-1:0] P = sfa_pkg::Prime;

    typedef enum logic [2:0] {
        S_IDLE, S_RED, S_SER, S_FIX, S_MUL, S_INV, S_OUT
    } t_state;

    t_state         r_state;
    logic [W-1:0]   r_x, r_y, r_z, r_c1, r_c2;
    logic [CW-1:0]  r_cnt;
    logic           r_carry, r_done, r_zf;
    logic [2:0]     r_op;

    logic [W:0]     w_dbl, w_dbl_r, w_sum, w_sum_r;
    logic [W:0]     w_xy;
    logic           w_bit, w_sb, w_co;
    logic [W-1:0]   w_h1, w_h2;
    logic [W:0]     w_xp;
    logic [W-1:0]   w_xr, w_yr;

    // half mod p of a residue
    function automatic logic [W-1:0] half_p(input logic [W-1:0] c);
        logic [W:0] t;
        t = c[0] ? ({1'b0, c} + {1'b0, P}) : {1'b0, c};
        return t[W:1];
    endfunction

    always_comb begin
        w_dbl   = {r_z, 1'b0};
        w_dbl_r = (w_dbl >= {1'b0, P}) ? w_dbl - {1'b0, P} : w_dbl;
        w_sum   = w_dbl_r + (r_x[W-1] ? {1'b0, r_y} : '0);
        w_sum_r = (w_sum >= {1'b0, P}) ? w_sum - {1'b0, P} : w_sum;
        w_xy    = {1'b0, r_x} - {1'b0, r_y};
        w_h1    = half_p(r_c1);
        w_h2    = half_p(r_c2);
        w_xp    = {1'b0, r_z} + {1'b0, P};
        // operands brought below p
        w_xr    = (r_x >= P) ? r_x - P : r_x;
        w_yr    = (r_y >= P) ? r_y - P : r_y;
        // serial bit adder: op select on lsb of x/y
        case (r_op)
            sfa_pkg::OP_ADD: {w_co, w_sb} = {1'b0, r_x[0]} + {1'b0, r_y[0]} + {1'b0, r_carry};
            default: {w_co, w_sb} = {1'b0, r_x[0]} - {1'b0, r_y[0]} - {1'b0, r_carry};
        endcase
        w_bit = w_sb;
    end

    always_ff @(posedge i_clk) begin
        r_done <= 1'b0;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_zf    <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: if (i_start) begin
                    r_op    <= i_op;
                    r_x     <= i_a;
                    r_y     <= i_b;
                    r_zf    <= 1'b0;
                    r_state <= S_RED;
                end
                S_RED: begin
                    r_cnt   <= '0;
                    r_carry <= 1'b0;
                    r_z     <= '0;
                    case (r_op)
                        sfa_pkg::OP_ADD, sfa_pkg::OP_SUB: begin
                            r_x     <= w_xr;
                            r_y     <= w_yr;
                            r_state <= S_SER;
                        end
                        sfa_pkg::OP_NEG: begin
                            // negate of zero stays zero
                            r_y     <= w_xr;
                            r_x     <= (w_xr == '0) ? '0 : P;
                            r_op    <= sfa_pkg::OP_SUB;
                            r_state <= S_SER;
                        end
                        sfa_pkg::OP_MUL: begin
                            r_x     <= w_xr;
                            r_y     <= w_yr;
                            r_state <= S_MUL;
                        end
                        sfa_pkg::OP_INV: begin
                            r_x  <= w_xr;
                            r_y  <= P;
                            r_c1 <= {{(W-1){1'b0}}, 1'b1};
                            r_c2 <= '0;
                            if (w_xr == '0) begin
                                r_zf    <= 1'b1;
                                r_state <= S_OUT;
                            end else begin
                                r_state <= S_INV;
                            end
                        end
                        default: r_state <= S_OUT;
                    endcase
                end
                S_SER: begin
                    r_x     <= r_x >> 1;
                    r_y     <= r_y >> 1;
                    r_z     <= {w_bit, r_z[W-1:1]};
                    r_carry <= w_co;
                    r_cnt   <= r_cnt + 1'b1;
                    if (r_cnt == CW'(W - 1)) r_state <= S_FIX;
                end
                S_FIX: begin
                    if (r_op == sfa_pkg::OP_ADD) begin
                        if (r_carry || r_z >= P) r_z <= r_z - P;
                    end else if (r_carry) begin
                        r_z <= w_xp[W-1:0];
                    end
                    r_state <= S_OUT;
                end
                S_MUL: begin
                    r_z   <= w_sum_r[W-1:0];
                    r_x   <= r_x << 1;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CW'(W - 1)) r_state <= S_OUT;
                end
                S_INV: begin
                    if (r_x == {{(W-1){1'b0}}, 1'b1}) begin
                        r_z <= r_c1; r_state <= S_OUT;
                    end else if (r_y == {{(W-1){1'b0}}, 1'b1}) begin
                        r_z <= r_c2; r_state <= S_OUT;
                    end else if (!r_x[0]) begin
                        r_x <= r_x >> 1; r_c1 <= w_h1;
                    end else if (!r_y[0]) begin
                        r_y <= r_y >> 1; r_c2 <= w_h2;
                    end else if (!w_xy[W]) begin
                        r_x  <= w_xy[W-1:0];
                        r_c1 <= (r_c1 >= r_c2) ? r_c1 - r_c2 : r_c1 - r_c2 + P;
                    end else begin
                        r_y  <= r_y - r_x;
                        r_c2 <= (r_c2 >= r_c1) ? r_c2 - r_c1 : r_c2 - r_c1 + P;
                    end
                end
                S_OUT: begin
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done     = r_done;
    assign o_res      = (r_zf || r_op > sfa_pkg::OP_INV) ? '0 : r_z;
    assign o_zero_inv = r_zf;
endmodule
`default_nettype wire

>>> rtl/secp256k1_field_alu.sv
// ----------------------------------------------------------------------------
// secp256k1_field_alu: modular arithmetic over p = 2^256 - 2^32 - 977
// Collects four operand limbs, runs a bit-serial engine, sends four limbs.
// ----------------------------------------------------------------------------
// channel | dir | tdata (low bit up)                 | tuser        | tlast
// s_axis  | in  | limb_index, a_limb, b_limb, 6 pad  | req_type     | -
// m_axis  | out | result_limb                        | result_index, zero_inverse | last
// Add/sub/neg work one bit per cycle, multiply one double-and-add per cycle
// and invert one Euclid step per cycle; an inverse of zero skips the Euclid
// steps. Limbs 0..2 do not hold off the input. Input is held off while an
// operation runs or results wait. Reset is synchronous.
// ----------------------------------------------------------------------------
`default_nettype none
module secp256k1_field_alu (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [135:0] s_axis_tdata,  // limb_index[1:0], a_limb, b_limb, pad
    input  wire logic [2:0]   s_axis_tuser,  // req_type
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [63:0]       m_axis_tdata,  // result_limb
    output logic [2:0]        m_axis_tuser,  // result_index[1:0], zero_inverse
    output logic              m_axis_tlast   // last
);
    localparam int unsigned W = sfa_pkg::FieldW;
    localparam int unsigned L = sfa_pkg::LimbW;

    logic [L-1:0]  r_a [4];
    logic [L-1:0]  r_b [4];
    logic [2:0]    r_op;
    logic          r_busy, r_start, r_send, r_zf;
    logic [1:0]    r_oidx;
    logic [W-1:0]  r_res;
    logic          w_acc, w_done, w_zi;
    logic [1:0]    w_idx;
    logic [W-1:0]  w_res;

    assign s_axis_tready = !r_busy;
    assign w_acc = s_axis_tvalid && s_axis_tready;
    assign w_idx = s_axis_tdata[1:0];

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_a[w_idx] <= s_axis_tdata[65:2];
            r_b[w_idx] <= s_axis_tdata[129:66];
        end
        if (w_done) begin
            r_res <= w_res;
            r_zf  <= w_zi;
        end else if (m_axis_tvalid && m_axis_tready) begin
            r_res <= r_res >> L;
        end
    end

    always_ff @(posedge i_clk) begin
        r_start <= 1'b0;
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_send <= 1'b0;
            r_oidx <= '0;
            r_op   <= '0;
        end else begin
            if (w_acc) begin
                r_op <= s_axis_tuser;
                if (w_idx == 2'd3) begin
                    r_busy  <= 1'b1;
                    r_start <= 1'b1;
                end
            end
            if (w_done) begin
                r_send <= 1'b1;
                r_oidx <= '0;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_oidx <= r_oidx + 1'b1;
                if (r_oidx == 2'd3) begin
                    r_send <= 1'b0;
                    r_busy <= 1'b0;
                end
            end
        end
    end

    sfa_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_start),
        .i_op      (r_op),
        .i_a       ({r_a[3], r_a[2], r_a[1], r_a[0]}),
        .i_b       ({r_b[3], r_b[2], r_b[1], r_b[0]}),
        .o_done    (w_done),
        .o_res     (w_res),
        .o_zero_inv(w_zi)
    );

    assign m_axis_tvalid = r_send;
    assign m_axis_tdata  = r_res[L-1:0];
    assign m_axis_tuser  = {r_zf, r_oidx};
    assign m_axis_tlast  = (r_oidx == 2'd3);

`ifndef SYNTHESIS
    a_no_in_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !s_axis_tready) else $error("input open during output");
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> r_busy) else $error("result without operation");
`endif
endmodule
`default_nettype wire

>>> dv/secp256k1_field_alu_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// secp256k1_field_alu_checker: result predictor and scoreboard
// Watches both stream channels of the field ALU. It keeps its own copy of
// the operand limbs and computes each expected residue with wide integer
// arithmetic. It then compares every result item, in order, field by field.
// ----------------------------------------------------------------------------
module secp256k1_field_alu_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [135:0] i_s_tdata,   // limb_index[1:0], a_limb, b_limb, pad
    input  logic [2:0]   i_s_tuser,   // req_type
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [63:0]  i_m_tdata,   // result_limb
    input  logic [2:0]   i_m_tuser,   // result_index[1:0], zero_inverse
    input  logic         i_m_tlast,
    output int           o_errors,
    output int           o_pending,
    output int           o_ops,
    output int           o_results
);
    localparam logic [511:0] PrimeWide = {256'd0, sfa_pkg::Prime};

    typedef struct packed {
        logic [63:0] limb;
        logic [1:0]  index;
        logic        last;
        logic        zero_inv;
    } t_limb_result;

    logic [63:0]  a_limbs [4];
    logic [63:0]  b_limbs [4];
    t_limb_result limb_queue [$];

    function automatic logic [255:0] mul_mod(logic [255:0] x, logic [255:0] y);
        logic [511:0] w;
        w = {256'd0, x} * {256'd0, y};
        return 256'(w % PrimeWide);
    endfunction

    // Fermat inverse: x^(p-2)
    function automatic logic [255:0] inv_mod(logic [255:0] x);
        logic [255:0] acc;
        logic [255:0] e;
        acc = 256'd1;
        e = sfa_pkg::Prime - 256'd2;
        for (int i = 255; i >= 0; i--) begin
            acc = mul_mod(acc, acc);
            if (e[i]) acc = mul_mod(acc, x);
        end
        return acc;
    endfunction

    function automatic logic [255:0] canon(logic [255:0] x);
        return (x >= sfa_pkg::Prime) ? x - sfa_pkg::Prime : x;
    endfunction

    task automatic predict_residue(input logic [2:0] op);
        logic [255:0] a;
        logic [255:0] b;
        logic [256:0] s;
        logic [255:0] r;
        logic         zf;
        t_limb_result e;
        a = canon({a_limbs[3], a_limbs[2], a_limbs[1], a_limbs[0]});
        b = canon({b_limbs[3], b_limbs[2], b_limbs[1], b_limbs[0]});
        r = '0;
        zf = 1'b0;
        case (op)
            sfa_pkg::OP_ADD: begin
                s = {1'b0, a} + {1'b0, b};
                r = (s >= {1'b0, sfa_pkg::Prime}) ? 256'(s - {1'b0, sfa_pkg::Prime})
                                                  : s[255:0];
            end
            sfa_pkg::OP_SUB: r = (a >= b) ? a - b : a + (sfa_pkg::Prime - b);
            sfa_pkg::OP_NEG: r = (a == '0) ? '0 : sfa_pkg::Prime - a;
            sfa_pkg::OP_MUL: r = mul_mod(a, b);
            sfa_pkg::OP_INV: begin
                if (a == '0) zf = 1'b1;
                else r = inv_mod(a);
            end
            default: r = '0;
        endcase
        for (int k = 0; k < 4; k++) begin
            e.limb = r[64*k +: 64];
            e.index = 2'(k);
            e.last = (k == 3);
            e.zero_inv = zf;
            limb_queue.insert(limb_queue.size(), e);
        end
    endtask

    always @(posedge i_clk) begin
        t_limb_result e;
        if (i_rst_n && i_s_tvalid && i_s_tready) begin
            a_limbs[i_s_tdata[1:0]] = i_s_tdata[65:2];
            b_limbs[i_s_tdata[1:0]] = i_s_tdata[129:66];
            if (i_s_tdata[1:0] == 2'd3) begin
                predict_residue(i_s_tuser);
                o_ops++;
            end
        end
        if (i_rst_n && i_m_tvalid && i_m_tready) begin
            o_results++;
            if (limb_queue.size() == 0) begin
                $error("unexpected result item: limb %h", i_m_tdata);
                o_errors++;
            end else begin
                e = limb_queue.pop_front();
                if (i_m_tdata !== e.limb) begin
                    $error("result_limb: expected %h, actual %h", e.limb, i_m_tdata);
                    o_errors++;
                end
                if (i_m_tuser[1:0] !== e.index) begin
                    $error("result_index: expected %0d, actual %0d", e.index,
                           i_m_tuser[1:0]);
                    o_errors++;
                end
                if (i_m_tlast !== e.last) begin
                    $error("last: expected %b, actual %b", e.last, i_m_tlast);
                    o_errors++;
                end
                if (i_m_tuser[2] !== e.zero_inv) begin
                    $error("zero_inverse: expected %b, actual %b", e.zero_inv,
                           i_m_tuser[2]);
                    o_errors++;
                end
            end
        end
        o_pending = limb_queue.size();
    end

    initial begin
        o_errors = 0;
        o_pending = 0;
        o_ops = 0;
        o_results = 0;
    end
endmodule

>>> dv/secp256k1_field_alu_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// secp256k1_field_alu_test: regression bench for the secp256k1 field ALU
// Sends directed and random four-limb operations, plus lone limbs, with random
// gaps, and stalls the result side at random, with one long stall. It reports
// the checker's verdict.
// ----------------------------------------------------------------------------
module secp256k1_field_alu_test;

    localparam int          CycleLimit = 1000000;
    localparam int          ItemTarget = 320;
    localparam int          LongHold   = 3000;
    localparam logic [2:0]  OpSpare7   = 3'd7;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [135:0] s_axis_tdata;   // limb_index[1:0], a_limb, b_limb, pad
    logic [2:0]   s_axis_tuser;   // req_type
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [63:0]  m_axis_tdata;   // result_limb
    logic [2:0]   m_axis_tuser;   // result_index[1:0], zero_inverse
    logic         m_axis_tlast;

    int errors, pending, ops, results;
    int sent_items;
    int cycles;

    secp256k1_field_alu u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    secp256k1_field_alu_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_s_tready (s_axis_tready),
        .i_s_tdata  (s_axis_tdata),
        .i_s_tuser  (s_axis_tuser),
        .i_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .i_m_tdata  (m_axis_tdata),
        .i_m_tuser  (m_axis_tuser),
        .i_m_tlast  (m_axis_tlast),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_ops      (ops),
        .o_results  (results)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("secp256k1_field_alu regression: fail");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(3, 1);
        return $urandom_range(60, 15);
    endfunction

    function automatic logic [255:0] pick_operand();
        logic [255:0] v;
        v = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom};
        case ($urandom_range(11))
            0: v = '0;
            1: v = 256'd1;
            2: v = sfa_pkg::Prime - 256'd1;
            3: v = sfa_pkg::Prime;
            4: v = '1;
            5: v = sfa_pkg::Prime + 256'(v[31:0] % 977);
            default: ;
        endcase
        return v;
    endfunction

    // one item, held until the block takes it
    task automatic send_limb(input logic [2:0] op, input logic [1:0] idx,
                             input logic [63:0] a, input logic [63:0] b);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (g) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {6'd0, b, a, idx};
        s_axis_tuser = op;
        do @(posedge i_clk); while (!s_axis_tready);
        sent_items++;
        @(negedge i_clk);
    endtask

    task automatic send_operation(input logic [2:0] op, input logic [255:0] a,
                                  input logic [255:0] b);
        for (int k = 0; k < 4; k++)
            send_limb(k == 3 ? op : 3'($urandom), 2'(k), a[64*k +: 64], b[64*k +: 64]);
    endtask

    // result side: random stalls, quiet stretches, one long hold
    initial begin
        bit held;
        bit busy_mode;
        int phase;
        held = 0;
        busy_mode = 1;
        phase = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && results >= 40) begin
                held = 1;
                m_axis_tready = 1'b0;
                for (int c = 0; c < LongHold; c++) @(negedge i_clk);
            end
            phase++;
            if (phase % 400 == 0) busy_mode = !busy_mode;
            if (!busy_mode) m_axis_tready = 1'b1;
            else if ($urandom_range(9) < 6) m_axis_tready = 1'b1;
            else if ($urandom_range(19) == 0) begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(40, 10)) @(negedge i_clk);
            end else m_axis_tready = 1'b0;
        end
    end

    initial begin
        logic [255:0] a, b;
        int wait_cycles;
        int r;
        cycles = 0;
        sent_items = 0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = sfa_pkg::OP_ADD;
        i_rst_n = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed
        send_operation(sfa_pkg::OP_ADD, '1, sfa_pkg::Prime - 256'd1);
        send_operation(sfa_pkg::OP_SUB, '0, 256'd1);
        send_operation(sfa_pkg::OP_NEG, '0, '1);
        send_operation(sfa_pkg::OP_MUL, '1, '1);
        send_operation(sfa_pkg::OP_INV, sfa_pkg::Prime, '0);
        send_operation(OpSpare7, pick_operand(), pick_operand());

        while (sent_items < ItemTarget) begin
            r = $urandom_range(99);
            a = pick_operand();
            b = pick_operand();
            if (r < 75) begin
                send_operation(3'($urandom_range(4)), a, b);
            end else if (r < 88) begin
                send_limb(3'($urandom), 2'($urandom_range(2)), a[63:0], b[63:0]);
            end else begin
                send_limb(3'($urandom_range(4)), 2'd3, a[255:192], b[255:192]);
            end
        end
        s_axis_tvalid = 1'b0;

        wait_cycles = 0;
        while (pending != 0 && wait_cycles < CycleLimit) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (200) @(posedge i_clk);

        $display("covered %0d input items, %0d operations, %0d result items",
                 sent_items, ops, results);
        $display("ops include operands at/above p, zero inverse and spare code");
        if (errors == 0 && pending == 0)
            $display("secp256k1_field_alu regression: pass");
        else
            $display("secp256k1_field_alu regression: fail");
        $finish;
    end
endmodule

>>> sim.f
rtl/sfa_pkg.sv
rtl/sfa_core.sv
rtl/secp256k1_field_alu.sv
dv/secp256k1_field_alu_checker.sv
dv/secp256k1_field_alu_test.sv
